// ===== design/iht_pkg.sv =====
`default_nettype none
package iht_pkg;

    typedef struct packed {
        logic [7:0] name_char;
        logic       last_char;
    } iht_in_t;

    typedef struct packed {
        logic       found;
        logic [9:0] name_index;
        logic [4:0] bucket;
        logic [1:0] error_code;
    } iht_out_t;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_STORE_FULL = 2'd1;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd2;

    localparam int SUM_W = 18;

endpackage
`default_nettype wire

// ===== design/identifier_hash_table_top.sv =====
`default_nettype none
// Channel  | Signals             | Handshake
// ---------+---------------------+--------------------------------------
// in       | start, busy, in_item| accepted when start && !busy
// out      | done, out_item      | one-cycle strobe, receiver can't stall
//
// A plain character item is taken in its accept cycle; busy stays low.
// A last-character item then holds busy for the terminator write and head read,
// plus the walk: per node hop a node read and a link step, per compared byte
// one read of each name through the single store port, then a compare; a miss
// adds an end check and a push. Store-full ends in the accept cycle. done follows.
// Reset clears control state and bucket valid bits; no clearing pass.
module identifier_hash_table_top
    import iht_pkg::*;
#(
    parameter int STORE_BYTES = 1024,
    parameter int BUCKETS     = 32,
    parameter int MAX_NAMES   = 256
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire iht_in_t in_item,
    output logic         busy,
    output logic         done,
    output iht_out_t     out_item
);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(MAX_NAMES);
    localparam int CW = $clog2(MAX_NAMES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TERM  = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_NODE  = 4'd3;
    localparam logic [3:0] S_RDA   = 4'd4;
    localparam logic [3:0] S_RDB   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;

    // memories
    logic [7:0]  store_mem [STORE_BYTES];
    logic [AW-1:0] node_start_mem [MAX_NAMES];
    logic [NW:0]   node_link_mem  [MAX_NAMES];   // node+1, 0 = end
    logic [NW:0]   head_reg [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;

    logic [3:0]   state_reg;
    logic [PW-1:0] free_reg;
    logic [AW-1:0] cur_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [BW-1:0] bkt_reg;
    logic [NW:0]   h_reg;
    logic [CW-1:0] steps_reg;
    logic [PW-1:0] pa_reg, pb_reg;
    logic [7:0]    rd_reg, ca_reg;
    logic [AW-1:0] ns_reg;
    logic [NW:0]   lk_reg;
    logic          done_reg;
    iht_out_t      out_reg;

    // single store port
    logic          st_we;
    logic [AW-1:0] st_addr;
    logic [7:0]    st_wd;

    logic acc, is_char;
    assign acc     = start && (state_reg == S_IDLE);
    assign is_char = in_item.name_char != 8'd0;
    assign busy    = state_reg != S_IDLE;
    assign done    = done_reg;
    assign out_item = out_reg;

    logic [SUM_W-1:0] sum_add;
    assign sum_add = is_char ? sum_reg + SUM_W'(in_item.name_char) : sum_reg;

    logic fits;
    assign fits = (free_reg < PW'(STORE_BYTES)) && !ovf_reg;

    always_comb
    begin
        st_we   = 1'b0;
        st_addr = free_reg[AW-1:0];
        st_wd   = in_item.name_char;
        case (state_reg)
            S_IDLE: st_we = acc && is_char && fits;
            S_TERM:
            begin
                st_we = 1'b1;
                st_wd = 8'd0;
            end
            S_RDA:   st_addr = pa_reg[AW-1:0];
            S_RDB:   st_addr = pb_reg[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_addr] <= st_wd;
        rd_reg <= store_mem[st_addr];
    end

    logic          push;
    logic [NW-1:0] rd_node;
    assign rd_node = h_reg[NW-1:0] - NW'(1);
    assign push = (state_reg == S_FIN) && (count_reg < CW'(MAX_NAMES));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            node_start_mem[count_reg[NW-1:0]] <= cur_reg;
            node_link_mem[count_reg[NW-1:0]]  <= head_vld_reg[bkt_reg] ? head_reg[bkt_reg]
                                                                       : '0;
            head_reg[bkt_reg] <= (NW+1)'(count_reg) + (NW+1)'(1);
        end
        ns_reg <= node_start_mem[rd_node];
        lk_reg <= node_link_mem[rd_node];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            free_reg     <= '0;
            cur_reg      <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            head_vld_reg <= '0;
            done_reg     <= 1'b0;
            bkt_reg      <= '0;
            h_reg        <= '0;
            steps_reg    <= '0;
            pa_reg       <= '0;
            pb_reg       <= '0;
            ca_reg       <= '0;
            out_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                if (acc)
                begin
                    if (is_char)
                    begin
                        if (fits) free_reg <= free_reg + PW'(1);
                        else      ovf_reg  <= 1'b1;
                    end
                    sum_reg <= sum_add;
                    if (in_item.last_char)
                    begin
                        // bucket index: sum mod BUCKETS (constant modulo)
                        bkt_reg <= BW'(sum_add % SUM_W'(BUCKETS));
                        if (ovf_reg || (is_char && !fits) ||
                            (free_reg + PW'(is_char && fits) >= PW'(STORE_BYTES)))
                        begin
                            out_reg.found      <= 1'b0;
                            out_reg.name_index <= 10'(cur_reg);
                            out_reg.bucket     <= 5'(sum_add % SUM_W'(BUCKETS));
                            out_reg.error_code <= ERR_STORE_FULL;
                            done_reg  <= 1'b1;
                            free_reg  <= PW'(cur_reg);
                            sum_reg   <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        else
                            state_reg <= S_TERM;
                    end
                end
                S_TERM:
                begin
                    free_reg  <= free_reg + PW'(1);
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    h_reg     <= head_vld_reg[bkt_reg] ? head_reg[bkt_reg] : '0;
                    steps_reg <= '0;
                    state_reg <= S_NODE;
                end
                S_NODE:
                // node memory read issued this cycle via rd_node
                if (h_reg == '0 || steps_reg >= count_reg)
                    state_reg <= S_FIN;
                else
                    state_reg <= S_LINK;
                S_LINK:
                begin
                    pa_reg    <= PW'(ns_reg);
                    pb_reg    <= PW'(cur_reg);
                    h_reg     <= lk_reg;
                    steps_reg <= steps_reg + CW'(1);
                    state_reg <= S_RDA;
                end
                S_RDA:
                state_reg <= S_RDB;
                S_RDB:
                begin
                    ca_reg    <= rd_reg;
                    state_reg <= S_CMP;
                end
                S_CMP:
                if (ca_reg != rd_reg)
                    state_reg <= S_NODE;
                else if (ca_reg == 8'd0)
                begin
                    out_reg.found      <= 1'b1;
                    out_reg.name_index <= 10'(pa_reg - (pb_reg - PW'(cur_reg)));
                    out_reg.bucket     <= 5'(bkt_reg);
                    out_reg.error_code <= ERR_NONE;
                    done_reg  <= 1'b1;
                    free_reg  <= PW'(cur_reg);
                    sum_reg   <= '0;
                    state_reg <= S_IDLE;
                end
                else if (pa_reg + PW'(1) >= PW'(STORE_BYTES) ||
                         pb_reg + PW'(1) >= PW'(STORE_BYTES))
                    state_reg <= S_NODE;
                else
                begin
                    pa_reg    <= pa_reg + PW'(1);
                    pb_reg    <= pb_reg + PW'(1);
                    state_reg <= S_RDA;
                end
                S_FIN:
                begin
                    out_reg.found      <= 1'b0;
                    out_reg.name_index <= 10'(cur_reg);
                    out_reg.bucket     <= 5'(bkt_reg);
                    done_reg <= 1'b1;
                    sum_reg  <= '0;
                    if (push)
                    begin
                        out_reg.error_code    <= ERR_NONE;
                        head_vld_reg[bkt_reg] <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                        cur_reg   <= free_reg[AW-1:0];
                    end
                    else
                    begin
                        out_reg.error_code <= ERR_TABLE_FULL;
                        free_reg <= PW'(cur_reg);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_NAMES)) else $error("node count overflow");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= PW'(STORE_BYTES)) else $error("free position overflow");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_item.error_code == ERR_NONE ||
                  out_item.error_code == ERR_STORE_FULL ||
                  out_item.error_code == ERR_TABLE_FULL)) else $error("bad error code");
endmodule
`default_nettype wire

// ===== test/identifier_hash_table_top_tb.sv =====
`default_nettype none
module identifier_hash_table_top_tb;
    import iht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 1024;
    localparam int BUCKETS     = 32;
    localparam int MAX_NAMES   = 256;
    localparam int POOL_CHARS  = 4;

    logic     clk;
    logic     rst_n;
    logic     start;
    iht_in_t  in_item;
    logic     busy;
    logic     done;
    iht_out_t out_item;

    identifier_hash_table_top #(
        .STORE_BYTES(STORE_BYTES),
        .BUCKETS    (BUCKETS),
        .MAX_NAMES  (MAX_NAMES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .done    (done),
        .out_item(out_item)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow of the interning table. Updated once per accepted item;
    // every name end pushes the result the block should report.
    // ------------------------------------------------------------------
    logic [7:0]  store_mem [STORE_BYTES];
    int          head_tbl  [BUCKETS];     // node + 1, zero means empty chain
    int          node_pos  [MAX_NAMES];
    int          node_next [MAX_NAMES];   // node + 1, zero ends the chain
    int          fill_ptr;
    int          name_base;
    logic [SUM_W-1:0] char_sum;
    int          names_used;
    bit          spill;                   // current name ran past the store

    iht_out_t    lookup_q [$];            // results still owed by the block
    int          fail_cnt;
    bit          quiet;                   // no sender gaps while set

    // Names sent so far, kept for replays (hits on existing entries).
    logic [8*POOL_CHARS-1:0] pool_txt [$];
    int                      pool_len [$];

    // exact compare up to both terminators
    function automatic bit names_match(int a, int b);
        for (int k = 0; k < STORE_BYTES; k++)
        begin
            if (a + k >= STORE_BYTES || b + k >= STORE_BYTES)
                return 1'b0;
            if (store_mem[a+k] != store_mem[b+k])
                return 1'b0;
            if (store_mem[a+k] == 8'h00)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic intern_predict(input iht_in_t it);
        iht_out_t r;
        int       h;
        int       n;
        int       steps;
        bit       hit;
        if (it.name_char != 8'h00)
        begin
            if (fill_ptr < STORE_BYTES && !spill)
            begin
                store_mem[fill_ptr] = it.name_char;
                fill_ptr++;
            end
            else
                spill = 1'b1;
            char_sum = char_sum + SUM_W'(it.name_char);
        end
        if (!it.last_char)
            return;

        r.found      = 1'b0;
        r.name_index = 10'(name_base);
        r.bucket     = 5'(char_sum % BUCKETS);
        r.error_code = ERR_NONE;

        if (spill || fill_ptr >= STORE_BYTES)
        begin
            r.error_code = ERR_STORE_FULL;
            fill_ptr     = name_base;
        end
        else
        begin
            store_mem[fill_ptr] = 8'h00;
            fill_ptr++;
            hit   = 1'b0;
            h     = head_tbl[r.bucket];
            steps = 0;
            while (h != 0 && steps < names_used && !hit)
            begin
                n = h - 1;
                if (names_match(node_pos[n], name_base))
                begin
                    hit          = 1'b1;
                    r.name_index = 10'(node_pos[n]);
                end
                h = node_next[n];
                steps++;
            end
            if (hit)
            begin
                r.found  = 1'b1;
                fill_ptr = name_base;
            end
            else if (names_used >= MAX_NAMES)
            begin
                r.error_code = ERR_TABLE_FULL;
                fill_ptr     = name_base;
            end
            else
            begin
                node_pos[names_used]  = name_base;
                node_next[names_used] = head_tbl[r.bucket];
                head_tbl[r.bucket]    = names_used + 1;
                names_used++;
            end
        end
        lookup_q.push_back(r);
        name_base = fill_ptr;
        char_sum  = '0;
        spill     = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result check: done is a one-cycle strobe, sampled at the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, out_item);
                fail_cnt++;
            end
            else
            begin
                automatic iht_out_t e = lookup_q.pop_front();
                if (out_item.found !== e.found)
                begin
                    $display("%0t: found exp %0d got %0d", $realtime, e.found,
                             out_item.found);
                    fail_cnt++;
                end
                if (out_item.name_index !== e.name_index)
                begin
                    $display("%0t: name_index exp %0d got %0d", $realtime,
                             e.name_index, out_item.name_index);
                    fail_cnt++;
                end
                if (out_item.bucket !== e.bucket)
                begin
                    $display("%0t: bucket exp %0d got %0d", $realtime, e.bucket,
                             out_item.bucket);
                    fail_cnt++;
                end
                if (out_item.error_code !== e.error_code)
                begin
                    $display("%0t: error_code exp %0d got %0d", $realtime,
                             e.error_code, out_item.error_code);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // random gap after an item, about 16 in 100
    task automatic sender_gap();
        if (!quiet && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // present one item and hold it until the block takes it
    task automatic send_char(input logic [7:0] ch, input logic lst);
        iht_in_t it;
        it.name_char = ch;
        it.last_char = lst;
        start   <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        intern_predict(it);
        sender_gap();
    endtask

    // whole name; occasional zero chars are ignored by the block
    task automatic send_name(input logic [8*POOL_CHARS-1:0] txt, input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                send_char(8'h00, 1'b0);
            send_char(txt[8*i +: 8], i == len - 1);
        end
        pool_txt.push_back(txt);
        pool_len.push_back(len);
    endtask

    // hold off until every owed result is back, plus walk time
    task automatic drain();
        start <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // extremes, empty name, prefix and same-bucket collisions
    task automatic test_directed();
        send_name(32'h0000_00FF, 1);
        send_name(32'h0000_0001, 1);
        send_char(8'h00, 1'b1);            // empty name
        send_char(8'h00, 1'b1);            // empty again: hit
        send_name(32'h0000_00FF, 1);       // hit
        send_name(32'h0000_0021, 1);       // bucket 1, like 8'h01
        send_name(32'h0000_2001, 2);       // 8'h01 is a prefix, same bucket
        send_name(32'h0000_0120, 2);       // permutation, same bucket
        send_name(32'h0000_0001, 1);       // hit deep in chain
        send_name(32'h0000_2001, 2);       // hit, exact only
        send_name(32'h5580_AA7F, 4);       // alternating bit patterns
        send_name(32'h5580_AA7F, 4);
        send_char(8'h00, 1'b0);            // zero without last: ignored
        send_name(32'h0000_0080, 1);
    endtask

    // mixed new names and replays until the name table overflows
    task automatic test_table_fill();
        logic [8*POOL_CHARS-1:0] txt;
        int                      len;
        int                      pick;
        int                      extra;
        int                      cnt;
        extra = 0;
        cnt   = 0;
        while (extra < 20)
        begin
            quiet = (cnt >= 100 && cnt < 160);
            if ($urandom_range(99) < 10)
            begin
                pick = $urandom_range(pool_txt.size() - 1);
                txt  = pool_txt[pick];
                len  = pool_len[pick];
            end
            else
            begin
                len = $urandom_range(1, 3);
                txt = '0;
                for (int i = 0; i < len; i++)
                    txt[8*i +: 8] = 8'($urandom_range(1, 255));
            end
            send_name(txt, len);
            if (names_used >= MAX_NAMES)
                extra++;
            cnt++;
        end
        quiet = 1'b0;
    endtask

    // one name longer than the space left in the store
    task automatic test_store_full();
        int len;
        len = STORE_BYTES - fill_ptr + 6;
        for (int i = 0; i < len; i++)
            send_char(8'hFF, i == len - 1);
        send_name(32'h0000_00FF, 1);       // table intact: hit
        send_char(8'h00, 1'b1);
        send_name(32'h0000_2001, 2);
    endtask

    initial
    begin
        start      = 1'b0;
        in_item    = '0;
        rst_n      = 1'b0;
        fail_cnt   = 0;
        quiet      = 1'b0;
        fill_ptr   = 0;
        name_base  = 0;
        char_sum   = '0;
        names_used = 0;
        spill      = 1'b0;
        foreach (store_mem[i]) store_mem[i] = 8'h00;
        foreach (head_tbl[i])  head_tbl[i]  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_fill();
        drain();
        test_store_full();
        drain();

        if (fail_cnt == 0)
            $display("[identifier_hash_table_top] OK");
        else
            $display("[identifier_hash_table_top] ERROR");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("[identifier_hash_table_top] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
